>>> sv/abq_pkg.sv
`default_nettype none

package abq_pkg;

    // Queue depth used when the top level is not overridden
    localparam int QUEUE_DEPTH_DEF = 8;

    // Fixed field widths
    localparam int ADDR_W   = 64;
    localparam int SIZE_W   = 32;
    localparam int TAG_W    = 64;
    localparam int CNT_W    = 4;
    localparam int TOTAL_W  = 32;
    localparam int LIMIT_W  = 4;
    localparam int FBYTES_W = 9;
    localparam int PROD_W   = SIZE_W + FBYTES_W;

    // Configuration port
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 9;
    localparam logic [LIMIT_W-1:0] LIMIT_RESET = 4'd2;
    localparam logic [LIMIT_W-1:0] LIMIT_ZERO_SUBST = 4'd2;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_QUEUE_LIMIT = 2'd0,
        REG_FRAME_BYTES = 2'd1,
        REG_UNUSED_2    = 2'd2,
        REG_UNUSED_3    = 2'd3
    } cfg_reg_t;

    typedef enum logic [1:0] {
        OP_ENQUEUE = 2'd0,
        OP_FILL    = 2'd1,
        OP_CLEAR   = 2'd2,
        OP_RSVD    = 2'd3
    } op_t;

    typedef enum logic [1:0] {
        KIND_ANSWER  = 2'd0,
        KIND_COPY    = 2'd1,
        KIND_SILENCE = 2'd2,
        KIND_RSVD    = 2'd3
    } kind_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_ANSWER,
        S_WANT,
        S_SCAN_RD,
        S_SCAN,
        S_EMIT_RD,
        S_EMIT,
        S_SILENCE
    } seq_state_t;

    typedef struct packed {
        logic [1:0]        op;
        logic [ADDR_W-1:0] buf_addr;
        logic [SIZE_W-1:0] buf_size;
        logic [TAG_W-1:0]  buf_tag;
        logic [SIZE_W-1:0] requested_frames;
        logic [SIZE_W-1:0] capacity_bytes;
    } in_item_t;

    typedef struct packed {
        logic [1:0]         kind;
        logic               accepted;
        logic [ADDR_W-1:0]  src_addr;
        logic [SIZE_W-1:0]  dst_offset;
        logic [SIZE_W-1:0]  seg_length;
        logic               drained;
        logic [TAG_W-1:0]   drained_tag;
        logic [SIZE_W-1:0]  fill_size;
        logic [CNT_W-1:0]   queue_count;
        logic [TOTAL_W-1:0] enqueued_total;
        logic               last;
    } out_item_t;

    // One stored buffer descriptor
    typedef struct packed {
        logic [ADDR_W-1:0] addr;
        logic [SIZE_W-1:0] size;
        logic [TAG_W-1:0]  tag;
    } desc_t;

endpackage

`default_nettype wire

>>> sv/abq_desc_ram.sv
`default_nettype none

// Descriptor store: one write port, one read port, registered read data
module abq_desc_ram #(
    parameter int QUEUE_DEPTH = abq_pkg::QUEUE_DEPTH_DEF,
    localparam int IDX_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1
) (
    input  wire logic              clk,
    input  wire logic              we,
    input  wire logic [IDX_W-1:0]  waddr,
    input  wire abq_pkg::desc_t    wdata,
    input  wire logic              re,
    input  wire logic [IDX_W-1:0]  raddr,
    output abq_pkg::desc_t         rdata
);
    import abq_pkg::*;

    desc_t mem [QUEUE_DEPTH];
    desc_t rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // read data holds while no read is issued
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

>>> sv/abq_seq.sv
`default_nettype none

// Sequencer: queue pointers, configuration, fill walk over the descriptor store
module abq_seq #(
    parameter int QUEUE_DEPTH = abq_pkg::QUEUE_DEPTH_DEF,
    localparam int IDX_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1
) (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         in_valid,
    output logic                              in_ready,
    input  wire abq_pkg::in_item_t            in_data,
    input  wire logic                         cfg_valid,
    input  wire logic [abq_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [abq_pkg::CFG_DATA_W-1:0] cfg_data,
    output logic                              push,
    output abq_pkg::out_item_t                res,
    input  wire logic                         slot_free,
    output logic                              ram_we,
    output logic [IDX_W-1:0]                  ram_waddr,
    output abq_pkg::desc_t                    ram_wdata,
    output logic                              ram_re,
    output logic [IDX_W-1:0]                  ram_raddr,
    input  wire abq_pkg::desc_t               ram_rdata
);
    import abq_pkg::*;

    function automatic logic [IDX_W-1:0] idx_inc(input logic [IDX_W-1:0] i);
        logic [IDX_W-1:0] r;
        r = (i == IDX_W'(QUEUE_DEPTH - 1)) ? '0 : i + IDX_W'(1);
        return r;
    endfunction

    seq_state_t          state_reg, state_next;
    logic [IDX_W-1:0]    head_reg, head_next;
    logic [IDX_W-1:0]    tail_reg, tail_next;
    logic [SIZE_W-1:0]   cons_reg, cons_next;
    logic [CNT_W-1:0]    pend_reg, pend_next;
    logic [TOTAL_W-1:0]  total_reg, total_next;
    logic [LIMIT_W-1:0]  qlim_reg, qlim_next;
    logic [FBYTES_W-1:0] fbytes_reg, fbytes_next;
    logic                acc_reg, acc_next;
    logic [PROD_W-1:0]   prod_reg, prod_next;
    logic [SIZE_W-1:0]   cap_reg, cap_next;
    logic                scale_reg, scale_next;
    logic [SIZE_W-1:0]   want_reg, want_next;
    logic [SIZE_W-1:0]   filled_reg, filled_next;
    logic [IDX_W-1:0]    sidx_reg, sidx_next;
    logic [SIZE_W-1:0]   scons_reg, scons_next;
    logic [SIZE_W-1:0]   sfilled_reg, sfilled_next;
    logic [CNT_W-1:0]    sleft_reg, sleft_next;
    logic [CNT_W-1:0]    final_reg, final_next;

    // shared segment math for the scan and emit passes
    logic [SIZE_W-1:0]  cur_cons, cur_filled, avail, room, take, filled_after;
    logic               drain;
    logic [LIMIT_W-1:0] lim;
    logic [SIZE_W-1:0]  want_calc;

    always_comb
    begin
        cur_cons     = (state_reg == S_SCAN) ? scons_reg : cons_reg;
        cur_filled   = (state_reg == S_SCAN) ? sfilled_reg : filled_reg;
        avail        = ram_rdata.size - cur_cons;
        room         = want_reg - cur_filled;
        drain        = (avail <= room);
        take         = drain ? avail : room;
        filled_after = cur_filled + take;
    end

    // effective queue limit: zero means two, capped at the store depth
    always_comb
    begin
        lim = (qlim_reg == '0) ? LIMIT_ZERO_SUBST : qlim_reg;
        if (32'(lim) > QUEUE_DEPTH)
        begin
            lim = LIMIT_W'(QUEUE_DEPTH);
        end
    end

    assign want_calc = (scale_reg && (prod_reg < PROD_W'(cap_reg))) ?
                       prod_reg[SIZE_W-1:0] : cap_reg;

    // configuration writes
    always_comb
    begin
        qlim_next   = qlim_reg;
        fbytes_next = fbytes_reg;
        if (cfg_valid)
        begin
            unique case (cfg_reg_t'(cfg_index))
                REG_QUEUE_LIMIT: qlim_next   = cfg_data[LIMIT_W-1:0];
                REG_FRAME_BYTES: fbytes_next = cfg_data[FBYTES_W-1:0];
                default:         ;
            endcase
        end
    end

    // next state and outputs
    always_comb
    begin
        state_next   = state_reg;
        head_next    = head_reg;
        tail_next    = tail_reg;
        cons_next    = cons_reg;
        pend_next    = pend_reg;
        total_next   = total_reg;
        acc_next     = acc_reg;
        prod_next    = prod_reg;
        cap_next     = cap_reg;
        scale_next   = scale_reg;
        want_next    = want_reg;
        filled_next  = filled_reg;
        sidx_next    = sidx_reg;
        scons_next   = scons_reg;
        sfilled_next = sfilled_reg;
        sleft_next   = sleft_reg;
        final_next   = final_reg;

        in_ready  = 1'b0;
        push      = 1'b0;
        res       = '0;
        ram_we    = 1'b0;
        ram_waddr = tail_reg;
        ram_wdata.addr = in_data.buf_addr;
        ram_wdata.size = in_data.buf_size;
        ram_wdata.tag  = in_data.buf_tag;
        ram_re    = 1'b0;
        ram_raddr = (state_reg == S_SCAN_RD) ? sidx_reg : head_reg;

        unique case (state_reg)
            S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    unique case (op_t'(in_data.op))
                        OP_ENQUEUE:
                        begin
                            acc_next = 1'b1;
                            if (in_data.buf_size != '0)
                            begin
                                if (pend_reg < lim)
                                begin
                                    ram_we     = 1'b1;
                                    tail_next  = idx_inc(tail_reg);
                                    pend_next  = pend_reg + CNT_W'(1);
                                    total_next = total_reg + TOTAL_W'(1);
                                end
                                else
                                begin
                                    acc_next = 1'b0;
                                end
                            end
                            state_next = S_ANSWER;
                        end
                        OP_FILL:
                        begin
                            prod_next  = PROD_W'(in_data.requested_frames) *
                                         PROD_W'(fbytes_reg);
                            cap_next   = in_data.capacity_bytes;
                            scale_next = (in_data.requested_frames != '0) &&
                                         (fbytes_reg != '0);
                            state_next = S_WANT;
                        end
                        OP_CLEAR:
                        begin
                            pend_next  = '0;
                            head_next  = '0;
                            tail_next  = '0;
                            cons_next  = '0;
                            acc_next   = 1'b1;
                            state_next = S_ANSWER;
                        end
                        OP_RSVD:
                        begin
                            acc_next   = 1'b0;
                            state_next = S_ANSWER;
                        end
                    endcase
                end
            end

            S_ANSWER:
            begin
                push               = 1'b1;
                res.kind           = KIND_ANSWER;
                res.accepted       = acc_reg;
                res.queue_count    = pend_reg;
                res.enqueued_total = total_reg;
                res.last           = 1'b1;
                if (slot_free)
                begin
                    state_next = S_IDLE;
                end
            end

            // bytes known; dry-run scan for the final count, or silence if none due
            S_WANT:
            begin
                want_next    = want_calc;
                filled_next  = '0;
                sidx_next    = head_reg;
                scons_next   = cons_reg;
                sfilled_next = '0;
                sleft_next   = pend_reg;
                final_next   = pend_reg;
                if ((want_calc == '0) || (pend_reg == '0))
                begin
                    state_next = S_SILENCE;
                end
                else
                begin
                    state_next = S_SCAN_RD;
                end
            end

            S_SCAN_RD:
            begin
                ram_re     = 1'b1;
                state_next = S_SCAN;
            end

            S_SCAN:
            begin
                sfilled_next = filled_after;
                if (drain)
                begin
                    sleft_next = sleft_reg - CNT_W'(1);
                    sidx_next  = idx_inc(sidx_reg);
                    scons_next = '0;
                    if ((sleft_reg == CNT_W'(1)) || (filled_after == want_reg))
                    begin
                        final_next = sleft_reg - CNT_W'(1);
                        state_next = S_EMIT_RD;
                    end
                    else
                    begin
                        state_next = S_SCAN_RD;
                    end
                end
                else
                begin
                    final_next = sleft_reg;
                    state_next = S_EMIT_RD;
                end
            end

            S_EMIT_RD:
            begin
                ram_re     = 1'b1;
                state_next = S_EMIT;
            end

            // one copy segment from the head descriptor
            S_EMIT:
            begin
                push               = 1'b1;
                res.kind           = KIND_COPY;
                res.src_addr       = ram_rdata.addr + ADDR_W'(cons_reg);
                res.dst_offset     = filled_reg;
                res.seg_length     = take;
                res.drained        = drain;
                res.drained_tag    = drain ? ram_rdata.tag : '0;
                res.fill_size      = want_reg;
                res.queue_count    = final_reg;
                res.enqueued_total = total_reg;
                res.last           = (filled_after == want_reg);
                if (slot_free)
                begin
                    filled_next = filled_after;
                    if (drain)
                    begin
                        cons_next = '0;
                        head_next = idx_inc(head_reg);
                        pend_next = pend_reg - CNT_W'(1);
                    end
                    else
                    begin
                        cons_next = cons_reg + take;
                    end
                    if (filled_after == want_reg)
                    begin
                        state_next = S_IDLE;
                    end
                    else if (drain && (pend_reg == CNT_W'(1)))
                    begin
                        state_next = S_SILENCE;
                    end
                    else
                    begin
                        state_next = S_EMIT_RD;
                    end
                end
            end

            // zero fill for whatever the queue could not supply
            S_SILENCE:
            begin
                push               = 1'b1;
                res.kind           = KIND_SILENCE;
                res.dst_offset     = filled_reg;
                res.seg_length     = want_reg - filled_reg;
                res.fill_size      = want_reg;
                res.queue_count    = final_reg;
                res.enqueued_total = total_reg;
                res.last           = 1'b1;
                if (slot_free)
                begin
                    state_next = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_IDLE;
            head_reg    <= '0;
            tail_reg    <= '0;
            cons_reg    <= '0;
            pend_reg    <= '0;
            total_reg   <= '0;
            qlim_reg    <= LIMIT_RESET;
            fbytes_reg  <= '0;
        end
        else
        begin
            state_reg   <= state_next;
            head_reg    <= head_next;
            tail_reg    <= tail_next;
            cons_reg    <= cons_next;
            pend_reg    <= pend_next;
            total_reg   <= total_next;
            qlim_reg    <= qlim_next;
            fbytes_reg  <= fbytes_next;
        end
    end

    // working registers of the current item
    always_ff @(posedge clk)
    begin
        acc_reg     <= acc_next;
        prod_reg    <= prod_next;
        cap_reg     <= cap_next;
        scale_reg   <= scale_next;
        want_reg    <= want_next;
        filled_reg  <= filled_next;
        sidx_reg    <= sidx_next;
        scons_reg   <= scons_next;
        sfilled_reg <= sfilled_next;
        sleft_reg   <= sleft_next;
        final_reg   <= final_next;
    end

endmodule

`default_nettype wire

>>> sv/audio_buffer_queue_filler_core.sv
`default_nettype none

// Channel  | Signals                                  | Direction
// ---------+------------------------------------------+----------
// in       | in_valid, in_ready, in_data              | request words in
// out      | out_valid, out_ready, out_data           | result words out
// cfg      | cfg_valid, cfg_ready, cfg_index, cfg_data| register writes in
//
// One request at a time. Enqueue and clear give one answer word. A fill is
// sized first, then reads each descriptor in a scan pass and again for each
// copy segment in the emit pass (both through the one read port of the
// descriptor store), plus a silence segment for any shortfall.
// Reset clears pointers, counts, frame size; limit goes to 2; descriptors kept.
// The output register takes the final word of a request, so the next request
// is taken while it waits; out_ready low stalls the sequencer on earlier words.
module audio_buffer_queue_filler_core #(
    parameter int QUEUE_DEPTH = abq_pkg::QUEUE_DEPTH_DEF
) (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           in_valid,
    output logic                                in_ready,
    input  wire abq_pkg::in_item_t              in_data,
    output logic                                out_valid,
    input  wire logic                           out_ready,
    output abq_pkg::out_item_t                  out_data,
    input  wire logic                           cfg_valid,
    output logic                                cfg_ready,
    input  wire logic [abq_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [abq_pkg::CFG_DATA_W-1:0] cfg_data
);
    import abq_pkg::*;

    localparam int IDX_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;

    logic             push;
    out_item_t        res;
    logic             slot_free;
    logic             ram_we;
    logic [IDX_W-1:0] ram_waddr;
    desc_t            ram_wdata;
    logic             ram_re;
    logic [IDX_W-1:0] ram_raddr;
    desc_t            ram_rdata;

    logic      out_valid_reg, out_valid_next;
    out_item_t out_data_reg;

    assign cfg_ready = 1'b1;

    abq_seq #(
        .QUEUE_DEPTH(QUEUE_DEPTH)
    ) u_seq (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .cfg_valid (cfg_valid),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .push      (push),
        .res       (res),
        .slot_free (slot_free),
        .ram_we    (ram_we),
        .ram_waddr (ram_waddr),
        .ram_wdata (ram_wdata),
        .ram_re    (ram_re),
        .ram_raddr (ram_raddr),
        .ram_rdata (ram_rdata)
    );

    abq_desc_ram #(
        .QUEUE_DEPTH(QUEUE_DEPTH)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // output register
    assign slot_free = !out_valid_reg || out_ready;

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (push && slot_free)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push && slot_free)
        begin
            out_data_reg <= res;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

endmodule

`default_nettype wire

>>> tb/audio_buffer_queue_filler_core_tb.sv
`timescale 1ns / 100ps

module audio_buffer_queue_filler_core_tb;

    import abq_pkg::*;

    localparam int DEPTH       = QUEUE_DEPTH_DEF;
    // longest fill: scan and emit passes over a full queue plus silence
    localparam int TAIL_CYCLES = 4 * DEPTH + 12;
    localparam int PHASE_ITEMS = 15;
    localparam int NUM_PHASES  = 6;

    // Predicts the words of each request and checks them in order
    class fill_scoreboard;
        desc_t             store[DEPTH];
        int                head;
        int                tail;
        int                pending;
        logic [SIZE_W-1:0]  consumed;
        logic [TOTAL_W-1:0] total;
        logic [LIMIT_W-1:0]  limit_reg;
        logic [FBYTES_W-1:0] fbytes_reg;
        out_item_t         expected_words[$];
        int                errors;

        function new();
            head       = 0;
            tail       = 0;
            pending    = 0;
            consumed   = '0;
            total      = '0;
            limit_reg  = LIMIT_RESET;
            fbytes_reg = '0;
            errors     = 0;
        endfunction

        function int waiting();
            return expected_words.size();
        endfunction

        function void write_reg(cfg_reg_t idx, logic [CFG_DATA_W-1:0] val);
            if (idx == REG_QUEUE_LIMIT)
                limit_reg = val[LIMIT_W-1:0];
            else if (idx == REG_FRAME_BYTES)
                fbytes_reg = val[FBYTES_W-1:0];
        endfunction

        // Work out the words one accepted request causes
        function void note_request(in_item_t it);
            out_item_t          words[$];
            out_item_t          w;
            logic [SIZE_W-1:0]  want;
            logic [SIZE_W-1:0]  filled;
            logic [SIZE_W-1:0]  avail;
            logic [SIZE_W-1:0]  room;
            logic [SIZE_W-1:0]  take;
            logic [PROD_W-1:0]  frame_prod;
            desc_t              d;
            int                 lim;
            w = '0;
            case (it.op)
                OP_ENQUEUE:
                begin
                    lim = (limit_reg == 0) ? int'(LIMIT_ZERO_SUBST) : int'(limit_reg);
                    if (lim > DEPTH)
                        lim = DEPTH;
                    w.kind = KIND_ANSWER;
                    w.accepted = 1'b1;
                    // zero size is acknowledged but never queued
                    if (it.buf_size != 0)
                    begin
                        if (pending >= lim)
                            w.accepted = 1'b0;
                        else
                        begin
                            store[tail].addr = it.buf_addr;
                            store[tail].size = it.buf_size;
                            store[tail].tag  = it.buf_tag;
                            tail = (tail + 1) % DEPTH;
                            pending++;
                            total++;
                        end
                    end
                    words = {words, w};
                end
                OP_FILL:
                begin
                    want   = it.capacity_bytes;
                    filled = '0;
                    if (it.requested_frames != 0 && fbytes_reg != 0)
                    begin
                        frame_prod = PROD_W'(it.requested_frames) * PROD_W'(fbytes_reg);
                        if (frame_prod < PROD_W'(it.capacity_bytes))
                            want = frame_prod[SIZE_W-1:0];
                    end
                    // one copy per head descriptor touched
                    while (filled < want && pending > 0)
                    begin
                        d     = store[head];
                        avail = d.size - consumed;
                        room  = want - filled;
                        take  = (avail < room) ? avail : room;
                        w            = '0;
                        w.kind       = KIND_COPY;
                        w.src_addr   = d.addr + ADDR_W'(consumed);
                        w.dst_offset = filled;
                        w.seg_length = take;
                        w.fill_size  = want;
                        consumed = consumed + take;
                        if (consumed >= d.size)
                        begin
                            w.drained     = 1'b1;
                            w.drained_tag = d.tag;
                            consumed = '0;
                            head = (head + 1) % DEPTH;
                            pending--;
                        end
                        words = {words, w};
                        filled = filled + take;
                    end
                    // silence pads the shortfall, or stands alone on a zero byte fill
                    if (filled < want || words.size() == 0)
                    begin
                        w            = '0;
                        w.kind       = KIND_SILENCE;
                        w.dst_offset = filled;
                        w.seg_length = want - filled;
                        w.fill_size  = want;
                        words = {words, w};
                    end
                end
                OP_CLEAR:
                begin
                    pending  = 0;
                    head     = 0;
                    tail     = 0;
                    consumed = '0;
                    w.kind = KIND_ANSWER;
                    w.accepted = 1'b1;
                    words = {words, w};
                end
                default:
                begin
                    w.kind = KIND_ANSWER;
                    words = {words, w};
                end
            endcase
            // counts are those after the whole request
            foreach (words[i])
            begin
                words[i].queue_count    = CNT_W'(pending);
                words[i].enqueued_total = total;
                words[i].last           = (i == words.size() - 1);
                expected_words = {expected_words, words[i]};
            end
        endfunction

        function void cmp(string name, logic [63:0] want_v, logic [63:0] got_v);
            if (want_v !== got_v)
            begin
                $error("%s: expected 0x%0h, got 0x%0h", name, want_v, got_v);
                errors++;
            end
        endfunction

        function void check_word(out_item_t got);
            out_item_t exp_w;
            if (expected_words.size() == 0)
            begin
                $error("result word with nothing expected, kind %0d", got.kind);
                errors++;
                return;
            end
            exp_w = expected_words[0];
            expected_words.delete(0);
            cmp("kind", exp_w.kind, got.kind);
            cmp("accepted", exp_w.accepted, got.accepted);
            cmp("src_addr", exp_w.src_addr, got.src_addr);
            cmp("dst_offset", exp_w.dst_offset, got.dst_offset);
            cmp("seg_length", exp_w.seg_length, got.seg_length);
            cmp("drained", exp_w.drained, got.drained);
            cmp("drained_tag", exp_w.drained_tag, got.drained_tag);
            cmp("fill_size", exp_w.fill_size, got.fill_size);
            cmp("queue_count", exp_w.queue_count, got.queue_count);
            cmp("enqueued_total", exp_w.enqueued_total, got.enqueued_total);
            cmp("last", exp_w.last, got.last);
        endfunction
    endclass

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  in_valid = 1'b0;
    logic                  in_ready;
    in_item_t              in_data = '0;
    logic                  out_valid;
    logic                  out_ready = 1'b0;
    out_item_t             out_data;
    logic                  cfg_valid = 1'b0;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data = '0;

    fill_scoreboard sb;
    int             burst_left = 0;
    int             stall_mode = 0;
    int             stall_left = 0;

    // queue_limit and frame_bytes per random phase, extremes included
    int phase_limit[NUM_PHASES] = '{8, 1, 4, 15, 0, 6};
    int phase_fbytes[NUM_PHASES] = '{4, 1, 256, 3, 0, 511};

    audio_buffer_queue_filler_core u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always #10 clk = ~clk;

    // Request builders; fields the op ignores carry random junk
    function automatic in_item_t mk_other(op_t op);
        in_item_t it;
        it.op               = op;
        it.buf_addr         = {$urandom, $urandom};
        it.buf_size         = $urandom;
        it.buf_tag          = {$urandom, $urandom};
        it.requested_frames = $urandom;
        it.capacity_bytes   = $urandom;
        return it;
    endfunction

    function automatic in_item_t mk_enq(logic [ADDR_W-1:0] addr, logic [SIZE_W-1:0] size,
                                        logic [TAG_W-1:0] tag);
        in_item_t it;
        it          = mk_other(OP_ENQUEUE);
        it.buf_addr = addr;
        it.buf_size = size;
        it.buf_tag  = tag;
        return it;
    endfunction

    function automatic in_item_t mk_fill(logic [SIZE_W-1:0] req, logic [SIZE_W-1:0] cap);
        in_item_t it;
        it                  = mk_other(OP_FILL);
        it.requested_frames = req;
        it.capacity_bytes   = cap;
        return it;
    endfunction

    // Mostly small buffers and fills so that fills split across descriptors
    function automatic in_item_t rand_request();
        int                pick;
        logic [SIZE_W-1:0] size;
        logic [SIZE_W-1:0] req;
        logic [SIZE_W-1:0] cap;
        pick = $urandom_range(0, 99);
        if (pick < 50)
        begin
            case ($urandom_range(0, 19))
                0:       size = '0;
                1:       size = $urandom;
                default: size = $urandom_range(1, 64);
            endcase
            return mk_enq({$urandom, $urandom}, size, {$urandom, $urandom});
        end
        else if (pick < 88)
        begin
            req = ($urandom_range(0, 9) == 0) ? $urandom : $urandom_range(0, 40);
            cap = ($urandom_range(0, 9) == 0) ? $urandom : $urandom_range(0, 160);
            return mk_fill(req, cap);
        end
        else if (pick < 96)
            return mk_other(OP_CLEAR);
        return mk_other(OP_RSVD);
    endfunction

    // Present one request word and hold it until taken
    task automatic send_item(in_item_t it);
        in_valid <= 1'b1;
        in_data  <= it;
        do
            @(posedge clk);
        while (!in_ready);
        sb.note_request(it);
    endtask

    // Burst pacing for the random part
    task automatic pace_sender();
        if (burst_left > 0)
            burst_left--;
        else
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 8)) @(posedge clk);
            burst_left = $urandom_range(0, 12);
        end
    endtask

    task automatic drain_results();
        in_valid <= 1'b0;
        while (sb.waiting() != 0)
            @(posedge clk);
    endtask

    task automatic cfg_put(cfg_reg_t idx, logic [CFG_DATA_W-1:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do
            @(posedge clk);
        while (!cfg_ready);
        sb.write_reg(idx, val);
    endtask

    // Registers change only with the block idle
    task automatic set_regs(int lim, int fbytes);
        drain_results();
        cfg_put(REG_QUEUE_LIMIT, CFG_DATA_W'(lim));
        cfg_put(REG_FRAME_BYTES, CFG_DATA_W'(fbytes));
        cfg_valid <= 1'b0;
    endtask

    // Result side: check each taken word, stall on a changing pattern
    initial
    begin
        forever
        begin
            @(posedge clk);
            if (rst_n && out_valid && out_ready)
                sb.check_word(out_data);
            if (stall_left == 0)
            begin
                stall_mode = $urandom_range(0, 3);
                stall_left = $urandom_range(16, 64);
            end
            stall_left--;
            case (stall_mode)
                0:       out_ready <= 1'b1;
                1:       out_ready <= $urandom_range(0, 1);
                2:       out_ready <= ($urandom_range(0, 3) == 0);
                default: out_ready <= ((stall_left % 4) < 2);
            endcase
        end
    end

    initial
    begin
        #10_000_000;
        $display("audio_buffer_queue_filler_core test failed");
        $finish;
    end

    initial
    begin
        sb = new();
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;

        // Reset settings: limit 2, frame scaling off
        send_item(mk_fill(0, 0));
        send_item(mk_fill(7, 100));
        send_item(mk_enq({$urandom, $urandom}, 0, {$urandom, $urandom}));
        send_item(mk_enq(64'hFFFF_FFFF_FFFF_FFF0, 10, '1));
        send_item(mk_enq(64'h1000, 20, '0));
        send_item(mk_enq(64'h2000, 5, 64'h55));
        send_item(mk_fill(0, 15));
        send_item(mk_fill(0, 100));
        send_item(mk_other(OP_RSVD));
        // full size buffer at the top of memory: source address wraps
        send_item(mk_enq('1, '1, {$urandom, $urandom}));
        send_item(mk_fill(0, 16));
        send_item(mk_fill(0, 16));
        send_item(mk_other(OP_CLEAR));
        send_item(mk_fill(0, 8));

        // Limit zero falls back to two; frame size 256
        drain_results();
        cfg_put(REG_UNUSED_2, '1);
        set_regs(0, 256);
        send_item(mk_enq(64'h4000, 300, 64'hA));
        send_item(mk_enq(64'h8000, 300, 64'hB));
        send_item(mk_enq(64'hC000, 1, 64'hC));
        send_item(mk_fill(1, 1000));
        send_item(mk_fill('1, '1));
        send_item(mk_fill(3, 5));

        // Limit above depth saturates; fill that walks the whole queue
        set_regs(15, 511);
        for (int i = 0; i <= DEPTH; i++)
            send_item(mk_enq({$urandom, $urandom}, 3 + i, {$urandom, $urandom}));
        send_item(mk_fill(2, '1));

        // Random phases, each with its own settings
        for (int p = 0; p < NUM_PHASES; p++)
        begin
            set_regs(phase_limit[p], phase_fbytes[p]);
            burst_left = $urandom_range(0, 12);
            for (int n = 0; n < PHASE_ITEMS; n++)
            begin
                send_item(rand_request());
                pace_sender();
            end
        end

        drain_results();
        repeat (TAIL_CYCLES) @(posedge clk);
        if (sb.errors == 0 && sb.waiting() == 0)
            $display("audio_buffer_queue_filler_core test passed");
        else
            $display("audio_buffer_queue_filler_core test failed");
        $finish;
    end

endmodule

>>> filelist.f
sv/abq_pkg.sv
sv/abq_desc_ram.sv
sv/abq_seq.sv
sv/audio_buffer_queue_filler_core.sv
tb/audio_buffer_queue_filler_core_tb.sv
